/* sv/image_rotation_inverse_map_unit_assert.svh */
// Assertion macros shared by the rotation unit modules.
`ifndef IMAGE_ROTATION_INVERSE_MAP_UNIT_ASSERT_SVH
`define IMAGE_ROTATION_INVERSE_MAP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define IRIM_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define IRIM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define IRIM_ASSERT_IMPL(label, ante, cons)
`define IRIM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/irim_pkg.sv */
// Shared types, constants and register codes of the rotation unit.
`default_nettype none
package irim_pkg;

	// Image geometry and number formats.
	localparam int SRC_DIM    = 256;
	localparam int SRC_AW     = 8;
	localparam int OUT_DIM    = 512;
	localparam int PIXEL_BITS = 24;
	localparam int FRAC_BITS  = 14;

	localparam int SDIM_W  = 9;
	localparam int ODIM_W  = 10;
	localparam int POS_W   = 9;
	localparam int TRIG_W  = 16;
	localparam int DELTA_W = 11;
	localparam int PROD_W  = DELTA_W + TRIG_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int COORD_W = SUM_W - FRAC_BITS;
	// Magnitude bits of a coordinate, below its sign bit.
	localparam int MAG_W   = COORD_W - 1;
	localparam int ADDR_W  = 2 * SRC_AW;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 16;

	typedef logic [SDIM_W-1:0]         sdim_t;
	typedef logic [ODIM_W-1:0]         odim_t;
	typedef logic [POS_W-1:0]          pos_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;
	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [COORD_W-1:0]        coord_t;
	typedef logic [PIXEL_BITS-1:0]     pix_t;
	typedef logic [ADDR_W-1:0]         addr_t;

	// Item operation codes.
	typedef enum logic {
		OP_STORE = 1'b0,
		OP_FETCH = 1'b1
	} op_t;

	// Configuration register indexes.
	typedef enum logic [CIDX_W-1:0] {
		REG_SRC_HEIGHT = 3'd0,
		REG_SRC_WIDTH  = 3'd1,
		REG_OUT_HEIGHT = 3'd2,
		REG_OUT_WIDTH  = 3'd3,
		REG_SINE       = 3'd4,
		REG_COSINE     = 3'd5,
		REG_TURN_LEFT  = 3'd6
	} cfg_reg_t;

	// Configuration as seen by the datapath, dimensions already saturated.
	typedef struct packed {
		sdim_t              src_h;
		sdim_t              src_w;
		logic [SRC_AW-1:0]  src_h_half;
		logic [SRC_AW-1:0]  src_w_half;
		logic [POS_W-1:0]   out_h_half;
		logic [POS_W-1:0]   out_w_half;
		trig_t              sine;
		trig_t              cosine;
		logic               turn_left;
	} cfg_t;

	// Item leaving the mapping pipeline toward the memory stage.
	typedef struct packed {
		logic   fetch;
		logic   store_ok;
		coord_t x;
		coord_t y;
		addr_t  waddr;
		pix_t   pixel;
	} map_item_t;

endpackage
`default_nettype wire

/* sv/image_rotation_inverse_map_unit.sv */
// Top level of the nearest-neighbour image rotation unit.
// Store items write one source pixel into a 256 x 256 image memory; fetch items name one
// output pixel, which is mapped back into the source image and answered with the source
// pixel, or with zero and a clear inside flag when it falls outside. One item is taken
// every cycle as long as results are taken; a fetch result held by a low out_ready stalls
// the items behind it. A fetch result passes through four register stages, which compute
// the offsets, the products with the Q2.14 sine and cosine, the sums and the truncated
// coordinates, and then through the registered memory read, which is the fifth register.
// Store items give no result. Reads keep order with earlier stores, so a pixel stored
// before a fetch is seen by it. Configuration must be written only while the unit is idle;
// the unit itself does not enforce this. The memory needs no clearing.
`default_nettype none
module image_rotation_inverse_map_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          operation,
	input  wire irim_pkg::pos_t                row,
	input  wire irim_pkg::pos_t                col,
	input  wire irim_pkg::pix_t                pixel_in,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output irim_pkg::pix_t                     pixel_out,
	output logic                               inside_res,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [irim_pkg::CIDX_W-1:0]   cfg_index,
	input  wire logic [irim_pkg::CDATA_W-1:0]  cfg_data
);

	irim_pkg::cfg_t      cfg;
	logic                m_valid;
	logic                m_ready;
	irim_pkg::map_item_t m_item;

	// Configuration registers.
	irim_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Coordinate mapping pipeline.
	irim_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.row       (row),
		.col       (col),
		.pixel_in  (pixel_in),
		.m_valid   (m_valid),
		.m_ready   (m_ready),
		.m_item    (m_item)
	);

	// Image memory and result register.
	irim_mem u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.m_valid    (m_valid),
		.m_ready    (m_ready),
		.m_item     (m_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.inside_res (inside_res)
	);

endmodule
`default_nettype wire

/* sv/irim_cfg.sv */
// Configuration registers of the rotation unit with dimension saturation.
`default_nettype none
module irim_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [irim_pkg::CIDX_W-1:0]   cfg_index,
	input  wire logic [irim_pkg::CDATA_W-1:0]  cfg_data,
	output irim_pkg::cfg_t                     cfg
);

	irim_pkg::sdim_t src_h_q;
	irim_pkg::sdim_t src_w_q;
	irim_pkg::odim_t out_h_q;
	irim_pkg::odim_t out_w_q;
	irim_pkg::trig_t sine_q;
	irim_pkg::trig_t cosine_q;
	logic            turn_left_q;

	irim_pkg::sdim_t sdim_sat;
	irim_pkg::odim_t odim_sat;

	// Writes are always taken.
	assign cfg_ready = 1'b1;

	// Saturate dimensions on the way in.
	always_comb begin
		sdim_sat = cfg_data[irim_pkg::SDIM_W-1:0];
		if (cfg_data[irim_pkg::SDIM_W-1:0] > irim_pkg::SDIM_W'(irim_pkg::SRC_DIM)) begin
			sdim_sat = irim_pkg::SDIM_W'(irim_pkg::SRC_DIM);
		end
		odim_sat = cfg_data[irim_pkg::ODIM_W-1:0];
		if (cfg_data[irim_pkg::ODIM_W-1:0] > irim_pkg::ODIM_W'(irim_pkg::OUT_DIM)) begin
			odim_sat = irim_pkg::ODIM_W'(irim_pkg::OUT_DIM);
		end
	end

	// Register file write decoder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_h_q     <= irim_pkg::SDIM_W'(256);
			src_w_q     <= irim_pkg::SDIM_W'(256);
			out_h_q     <= irim_pkg::ODIM_W'(256);
			out_w_q     <= irim_pkg::ODIM_W'(256);
			sine_q      <= '0;
			cosine_q    <= irim_pkg::TRIG_W'(16384);
			turn_left_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				irim_pkg::REG_SRC_HEIGHT: src_h_q     <= sdim_sat;
				irim_pkg::REG_SRC_WIDTH:  src_w_q     <= sdim_sat;
				irim_pkg::REG_OUT_HEIGHT: out_h_q     <= odim_sat;
				irim_pkg::REG_OUT_WIDTH:  out_w_q     <= odim_sat;
				irim_pkg::REG_SINE:       sine_q      <= cfg_data;
				irim_pkg::REG_COSINE:     cosine_q    <= cfg_data;
				irim_pkg::REG_TURN_LEFT:  turn_left_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Halves are rounded down, so they are plain shifts.
	always_comb begin
		cfg.src_h      = src_h_q;
		cfg.src_w      = src_w_q;
		cfg.src_h_half = src_h_q[irim_pkg::SDIM_W-1:1];
		cfg.src_w_half = src_w_q[irim_pkg::SDIM_W-1:1];
		cfg.out_h_half = out_h_q[irim_pkg::ODIM_W-1:1];
		cfg.out_w_half = out_w_q[irim_pkg::ODIM_W-1:1];
		cfg.sine       = sine_q;
		cfg.cosine     = cosine_q;
		cfg.turn_left  = turn_left_q;
	end

endmodule
`default_nettype wire

/* sv/irim_map.sv */
// Four-stage pipeline mapping an output position back to a source position.
`default_nettype none
`include "image_rotation_inverse_map_unit_assert.svh"
module irim_map (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire irim_pkg::cfg_t       cfg,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 operation,
	input  wire irim_pkg::pos_t       row,
	input  wire irim_pkg::pos_t       col,
	input  wire irim_pkg::pix_t       pixel_in,
	output logic                      m_valid,
	input  wire logic                 m_ready,
	output irim_pkg::map_item_t       m_item
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_1, rdy_2, rdy_3, rdy_4;

	// Stage 1: offsets from the output center.
	logic              fetch_s1, store_ok_s1;
	irim_pkg::delta_t  dr_s1, dc_s1;
	irim_pkg::addr_t   waddr_s1;
	irim_pkg::pix_t    pixel_s1;

	// Stage 2: the four products.
	logic              fetch_s2, store_ok_s2;
	irim_pkg::prod_t   p_rc_s2, p_cs_s2, p_cc_s2, p_rs_s2;
	irim_pkg::addr_t   waddr_s2;
	irim_pkg::pix_t    pixel_s2;

	// Stage 3: fixed-point source coordinates.
	logic              fetch_s3, store_ok_s3;
	irim_pkg::sum_t    xs_s3, ys_s3;
	irim_pkg::addr_t   waddr_s3;
	irim_pkg::pix_t    pixel_s3;

	// Stage 4: integer coordinates, truncated toward zero.
	irim_pkg::map_item_t item_s4;

	irim_pkg::sum_t    xs_c, ys_c, xt_c, yt_c;
	logic              src_ok_c;

	// Each stage moves when it is empty or the one after it moves.
	assign rdy_4    = !v_s4 || m_ready;
	assign rdy_3    = !v_s3 || rdy_4;
	assign rdy_2    = !v_s2 || rdy_3;
	assign rdy_1    = !v_s1 || rdy_2;
	assign in_ready = rdy_1;
	assign m_valid  = v_s4;
	assign m_item   = item_s4;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_1) v_s1 <= in_valid;
			if (rdy_2) v_s2 <= v_s1;
			if (rdy_3) v_s3 <= v_s2;
			if (rdy_4) v_s4 <= v_s3;
		end
	end

	// A store keeps only positions inside the source store.
	assign src_ok_c = (row < irim_pkg::POS_W'(irim_pkg::SRC_DIM)) &&
		(col < irim_pkg::POS_W'(irim_pkg::SRC_DIM));

	always_ff @(posedge clk) begin
		if (rdy_1) begin
			fetch_s1    <= (operation == irim_pkg::OP_FETCH);
			store_ok_s1 <= src_ok_c;
			dr_s1       <= irim_pkg::delta_t'(row) - irim_pkg::delta_t'(cfg.out_h_half);
			dc_s1       <= irim_pkg::delta_t'(col) - irim_pkg::delta_t'(cfg.out_w_half);
			waddr_s1    <= {row[irim_pkg::SRC_AW-1:0], col[irim_pkg::SRC_AW-1:0]};
			pixel_s1    <= pixel_in;
		end
	end

	// Multipliers, one register after each.
	always_ff @(posedge clk) begin
		if (rdy_2) begin
			fetch_s2    <= fetch_s1;
			store_ok_s2 <= store_ok_s1;
			p_rc_s2     <= irim_pkg::prod_t'(dr_s1) * irim_pkg::prod_t'(cfg.cosine);
			p_cs_s2     <= irim_pkg::prod_t'(dc_s1) * irim_pkg::prod_t'(cfg.sine);
			p_cc_s2     <= irim_pkg::prod_t'(dc_s1) * irim_pkg::prod_t'(cfg.cosine);
			p_rs_s2     <= irim_pkg::prod_t'(dr_s1) * irim_pkg::prod_t'(cfg.sine);
			waddr_s2    <= waddr_s1;
			pixel_s2    <= pixel_s1;
		end
	end

	// Combine products by rotation direction and add the source center.
	always_comb begin
		if (cfg.turn_left) begin
			xs_c = irim_pkg::sum_t'(p_rc_s2) + irim_pkg::sum_t'(p_cs_s2);
			ys_c = irim_pkg::sum_t'(p_cc_s2) - irim_pkg::sum_t'(p_rs_s2);
		end else begin
			xs_c = irim_pkg::sum_t'(p_rc_s2) - irim_pkg::sum_t'(p_cs_s2);
			ys_c = irim_pkg::sum_t'(p_cc_s2) + irim_pkg::sum_t'(p_rs_s2);
		end
		xs_c = xs_c + (irim_pkg::sum_t'(cfg.src_h_half) << irim_pkg::FRAC_BITS);
		ys_c = ys_c + (irim_pkg::sum_t'(cfg.src_w_half) << irim_pkg::FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (rdy_3) begin
			fetch_s3    <= fetch_s2;
			store_ok_s3 <= store_ok_s2;
			xs_s3       <= xs_c;
			ys_s3       <= ys_c;
			waddr_s3    <= waddr_s2;
			pixel_s3    <= pixel_s2;
		end
	end

	// Negative sums get a bias of one less than unity so the shift truncates toward zero.
	always_comb begin
		xt_c = xs_s3;
		yt_c = ys_s3;
		if (xs_s3[irim_pkg::SUM_W-1]) begin
			xt_c = xs_s3 + irim_pkg::sum_t'((1 << irim_pkg::FRAC_BITS) - 1);
		end
		if (ys_s3[irim_pkg::SUM_W-1]) begin
			yt_c = ys_s3 + irim_pkg::sum_t'((1 << irim_pkg::FRAC_BITS) - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_4) begin
			item_s4.fetch    <= fetch_s3;
			item_s4.store_ok <= store_ok_s3;
			item_s4.x        <= xt_c[irim_pkg::SUM_W-1:irim_pkg::FRAC_BITS];
			item_s4.y        <= yt_c[irim_pkg::SUM_W-1:irim_pkg::FRAC_BITS];
			item_s4.waddr    <= waddr_s3;
			item_s4.pixel    <= pixel_s3;
		end
	end

	// The input stalls only when every stage holds an item.
	`IRIM_ASSERT_IMPL(a_stall_only_full, !rdy_1, v_s1 && v_s2 && v_s3 && v_s4)
	// An accepted item lands in stage 1.
	`IRIM_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, v_s1)
	// A stalled stage 3 item keeps its sums.
	`IRIM_ASSERT_NEXT(a_s3_holds, v_s3 && !rdy_3, v_s3 && $stable(xs_s3) && $stable(ys_s3))

endmodule
`default_nettype wire

/* sv/irim_mem.sv */
// Source image memory with bounds check and the result register.
`default_nettype none
`include "image_rotation_inverse_map_unit_assert.svh"
module irim_mem (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire irim_pkg::cfg_t       cfg,
	input  wire logic                 m_valid,
	output logic                      m_ready,
	input  wire irim_pkg::map_item_t  m_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output irim_pkg::pix_t            pixel_out,
	output logic                      inside_res
);

	irim_pkg::pix_t  image_mem [1 << irim_pkg::ADDR_W];

	logic            v_s5;
	logic            inside_s5;
	irim_pkg::pix_t  pix_s5;

	logic            inside_c;
	logic            wr_en;
	logic            rd_take;
	irim_pkg::addr_t raddr;

	// Bounds check on the truncated coordinates.
	assign inside_c = !m_item.x[irim_pkg::COORD_W-1] && !m_item.y[irim_pkg::COORD_W-1] &&
		(m_item.x[irim_pkg::MAG_W-1:0] < irim_pkg::MAG_W'(cfg.src_h)) &&
		(m_item.y[irim_pkg::MAG_W-1:0] < irim_pkg::MAG_W'(cfg.src_w));
	assign raddr = {m_item.x[irim_pkg::SRC_AW-1:0], m_item.y[irim_pkg::SRC_AW-1:0]};

	// Stores never wait; a fetch waits for room in the result register.
	assign m_ready = !m_item.fetch || !v_s5 || out_ready;
	assign wr_en   = m_valid && !m_item.fetch && m_item.store_ok;
	assign rd_take = m_valid && m_item.fetch && m_ready;

	// Single-port memory: an item either writes or reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			image_mem[m_item.waddr] <= m_item.pixel;
		end
		if (rd_take) begin
			pix_s5 <= image_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rd_take) begin
			v_s5 <= 1'b1;
		end else if (out_ready) begin
			v_s5 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_take) begin
			inside_s5 <= inside_c;
		end
	end

	// Outside positions read as zero.
	assign out_valid  = v_s5;
	assign inside_res = inside_s5;
	assign pixel_out  = inside_s5 ? pix_s5 : '0;

	// Store items pass without waiting.
	`IRIM_ASSERT_IMPL(a_store_no_wait, m_valid && !m_item.fetch, m_ready)
	// A waiting result is never overwritten by a new read.
	`IRIM_ASSERT_IMPL(a_no_read_over_result, v_s5 && !out_ready, !rd_take)
	// An outside result carries a zero pixel.
	`IRIM_ASSERT_IMPL(a_outside_zero, out_valid && !inside_res, pixel_out == '0)

endmodule
`default_nettype wire

/* sim/image_rotation_inverse_map_unit_tb.sv */
// Self-checking testbench for the image rotation inverse-map unit.
`timescale 1ns / 1ps
module image_rotation_inverse_map_unit_tb;
	import irim_pkg::*;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 10;
	localparam int STALL_LIMIT   = 4000;
	localparam int HOLDOFF_LEN   = 400;
	localparam int IMG_WORDS     = SRC_DIM * SRC_DIM;
	localparam logic [CIDX_W-1:0] REG_UNUSED = 3'd7;

	// One input item and one fetch result as the testbench sees them.
	typedef struct packed {
		op_t  op;
		pos_t row;
		pos_t col;
		pix_t pixel;
	} pixel_item_t;

	typedef struct packed {
		pix_t pixel;
		logic hit_src;
	} rotated_pixel_t;

	typedef enum {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = OP_STORE;
	pos_t row = '0;
	pos_t col = '0;
	pix_t pixel_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pix_t pixel_out;
	logic inside_res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CDATA_W-1:0] cfg_data = '0;

	// Register shadow, holding the raw values as written.
	sdim_t src_h_reg = 9'd256;
	sdim_t src_w_reg = 9'd256;
	odim_t out_h_reg = 10'd256;
	odim_t out_w_reg = 10'd256;
	trig_t sine_reg = 16'sd0;
	trig_t cosine_reg = 16'sd16384;
	logic turn_left_reg = 1'b0;

	// Image contents seen by the predictor, and entries already staged by the generator.
	pix_t source_copy [IMG_WORDS];
	bit staged [IMG_WORDS];

	pixel_item_t items_to_send [$];
	rotated_pixel_t rotated_pixels_due [$];

	int mismatches = 0;
	int stores_taken = 0;
	int fetches_checked = 0;
	int inside_hits = 0;
	int settings_run = 1;

	image_rotation_inverse_map_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.row(row),
		.col(col),
		.pixel_in(pixel_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_out(pixel_out),
		.inside_res(inside_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Map an output position back to the source image under the current registers.
	function automatic void map_to_source(input pos_t r, input pos_t c, output bit hit,
			output longint sx, output longint sy);
		longint one, hs, ws, oh, ow, dr, dc, sn, cs, xs, ys;
		one = longint'(1) << FRAC_BITS;
		hs = (src_h_reg > SRC_DIM) ? longint'(SRC_DIM) : longint'(src_h_reg);
		ws = (src_w_reg > SRC_DIM) ? longint'(SRC_DIM) : longint'(src_w_reg);
		oh = (out_h_reg > OUT_DIM) ? longint'(OUT_DIM) : longint'(out_h_reg);
		ow = (out_w_reg > OUT_DIM) ? longint'(OUT_DIM) : longint'(out_w_reg);
		dr = longint'(r) - oh / 2;
		dc = longint'(c) - ow / 2;
		sn = longint'(sine_reg);
		cs = longint'(cosine_reg);
		if (turn_left_reg) begin
			xs = dr * cs + dc * sn;
			ys = dc * cs - dr * sn;
		end else begin
			xs = dr * cs - dc * sn;
			ys = dc * cs + dr * sn;
		end
		// Signed division truncates toward zero, as the hardware does.
		sx = (xs + (hs / 2) * one) / one;
		sy = (ys + (ws / 2) * one) / one;
		hit = (sx >= 0) && (sx < hs) && (sy >= 0) && (sy < ws);
	endfunction

	task automatic queue_store(input pos_t r, input pos_t c, input pix_t p);
		pixel_item_t it;
		it.op = OP_STORE;
		it.row = r;
		it.col = c;
		it.pixel = p;
		if (r < SRC_DIM && c < SRC_DIM)
			staged[r * SRC_DIM + c] = 1'b1;
		items_to_send.push_back(it);
	endtask

	// A fetch whose source pixel was never stored gets that pixel stored first.
	task automatic queue_fetch(input pos_t r, input pos_t c);
		pixel_item_t it;
		bit hit;
		longint sx, sy;
		map_to_source(r, c, hit, sx, sy);
		if (hit && !staged[sx * SRC_DIM + sy])
			queue_store(pos_t'(sx), pos_t'(sy), pix_t'($urandom));
		it.op = OP_FETCH;
		it.row = r;
		it.col = c;
		it.pixel = pix_t'($urandom);
		items_to_send.push_back(it);
	endtask

	// Random traffic: mostly fetches inside the output frame, plus stores and stray positions.
	task automatic queue_random_items(input int count);
		int kind, oh, ow;
		pos_t r, c;
		oh = (out_h_reg > OUT_DIM) ? OUT_DIM : int'(out_h_reg);
		ow = (out_w_reg > OUT_DIM) ? OUT_DIM : int'(out_w_reg);
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				r = ($urandom_range(0, 9) == 0) ? pos_t'($urandom_range(0, 511))
					: pos_t'($urandom_range(0, SRC_DIM - 1));
				c = ($urandom_range(0, 9) == 0) ? pos_t'($urandom_range(0, 511))
					: pos_t'($urandom_range(0, SRC_DIM - 1));
				queue_store(r, c, pix_t'($urandom));
			end else if (kind < 90 && oh > 0 && ow > 0) begin
				r = pos_t'($urandom_range(0, oh - 1));
				c = pos_t'($urandom_range(0, ow - 1));
				queue_fetch(r, c);
			end else begin
				queue_fetch(pos_t'($urandom_range(0, 511)), pos_t'($urandom_range(0, 511)));
			end
		end
	endtask

	task automatic wait_until_drained();
		do
			@(negedge clk);
		while (items_to_send.size() != 0 || in_valid || rotated_pixels_due.size() != 0);
		// Stores give no result and may still be in flight.
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SRC_HEIGHT: src_h_reg = data[SDIM_W-1:0];
			REG_SRC_WIDTH:  src_w_reg = data[SDIM_W-1:0];
			REG_OUT_HEIGHT: out_h_reg = data[ODIM_W-1:0];
			REG_OUT_WIDTH:  out_w_reg = data[ODIM_W-1:0];
			REG_SINE:       sine_reg = data;
			REG_COSINE:     cosine_reg = data;
			REG_TURN_LEFT:  turn_left_reg = data[0];
			default: ;
		endcase
	endtask

	// Wait for the unit to go idle, load a full register set, then queue random items.
	task automatic run_setting(input int sh, input int sw, input int oh, input int ow,
			input int sn, input int cs, input int tl, input int count);
		wait_until_drained();
		write_reg(REG_SRC_HEIGHT, CDATA_W'(sh));
		write_reg(REG_SRC_WIDTH, CDATA_W'(sw));
		write_reg(REG_OUT_HEIGHT, CDATA_W'(oh));
		write_reg(REG_OUT_WIDTH, CDATA_W'(ow));
		write_reg(REG_SINE, CDATA_W'(sn));
		write_reg(REG_COSINE, CDATA_W'(cs));
		write_reg(REG_TURN_LEFT, CDATA_W'(tl));
		settings_run++;
		queue_random_items(count);
	endtask

	// Driver: sends queued items in bursts and predicts each accepted item.
	pixel_item_t offered = '0;
	rotated_pixel_t due_item;
	int burst_left = 0;
	int gap_left = 0;
	bit drv_hit;
	longint drv_x, drv_y;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (offered.op == OP_STORE) begin
					if (offered.row < SRC_DIM && offered.col < SRC_DIM)
						source_copy[offered.row * SRC_DIM + offered.col] = offered.pixel;
					stores_taken++;
				end else begin
					map_to_source(offered.row, offered.col, drv_hit, drv_x, drv_y);
					due_item.hit_src = drv_hit;
					due_item.pixel = drv_hit ? source_copy[drv_x * SRC_DIM + drv_y] : '0;
					rotated_pixels_due.push_back(due_item);
				end
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (items_to_send.size() != 0) begin
					offered = items_to_send.pop_front();
					in_valid <= 1'b1;
					operation <= offered.op;
					row <= offered.row;
					col <= offered.col;
					pixel_in <= offered.pixel;
					burst_left--;
					if (burst_left <= 0) begin
						// Some bursts run long with no gap after them.
						if ($urandom_range(0, 4) == 0) begin
							burst_left = $urandom_range(40, 120);
							gap_left = 0;
						end else begin
							burst_left = $urandom_range(1, 24);
							gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 25)
								: $urandom_range(1, 6);
						end
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result against the oldest prediction and paces out_ready.
	rotated_pixel_t expected_pixel;
	rx_mode_t rx_mode = RX_STEADY;
	int rx_segment_left = 0;
	int holdoff_left = 0;
	bit holdoff_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (rotated_pixels_due.size() == 0) begin
					$display("%0t: result with nothing expected, pixel_out %06h inside_res %0b",
						$time, pixel_out, inside_res);
					mismatches++;
				end else begin
					expected_pixel = rotated_pixels_due.pop_front();
					fetches_checked++;
					if (expected_pixel.hit_src)
						inside_hits++;
					if (pixel_out !== expected_pixel.pixel) begin
						$display("%0t: pixel_out expected %06h, actual %06h",
							$time, expected_pixel.pixel, pixel_out);
						mismatches++;
					end
					if (inside_res !== expected_pixel.hit_src) begin
						$display("%0t: inside_res expected %0b, actual %0b",
							$time, expected_pixel.hit_src, inside_res);
						mismatches++;
					end
				end
			end
			// One long hold-off while plenty of items are still queued, so the unit backs up.
			if (!holdoff_done && fetches_checked >= 10 && items_to_send.size() > 60) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_LEN;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				out_ready <= 1'b0;
			end else begin
				if (rx_segment_left == 0) begin
					rx_segment_left = $urandom_range(8, 64);
					rx_mode = rx_mode_t'($urandom_range(0, 2));
				end
				rx_segment_left--;
				case (rx_mode)
					RX_STEADY: out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					default:   out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Watchdog on cycles in which no channel moves anything.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d results still due",
					$time, STALL_LIMIT, rotated_pixels_due.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items under the reset registers, which map each position onto itself.
		queue_store(9'd0, 9'd0, 24'hFFFFFF);
		queue_store(9'd255, 9'd255, 24'h000000);
		queue_store(9'd0, 9'd255, 24'hA5A5A5);
		queue_store(9'd255, 9'd0, 24'h5A5A5A);
		// Stores beyond the memory are dropped.
		queue_store(9'd511, 9'd511, 24'h123456);
		queue_store(9'd256, 9'd7, 24'h654321);
		queue_store(9'd7, 9'd300, 24'h0F0F0F);
		queue_fetch(9'd0, 9'd0);
		queue_fetch(9'd255, 9'd255);
		queue_fetch(9'd0, 9'd255);
		queue_fetch(9'd255, 9'd0);
		// Positions past the output size map outside the source.
		queue_fetch(9'd256, 9'd0);
		queue_fetch(9'd0, 9'd256);
		queue_fetch(9'd511, 9'd511);
		// A fetch right behind a store to the same pixel must see the new value.
		queue_store(9'd10, 9'd20, 24'h00F00F);
		queue_fetch(9'd10, 9'd20);
		queue_store(9'd10, 9'd20, 24'h0FF0F0);
		queue_fetch(9'd10, 9'd20);
		queue_fetch(9'd7, 9'd7);
		queue_random_items(250);

		// 45 degrees right into a larger frame.
		run_setting(256, 256, 512, 512, 11585, 11585, 0, 80);
		// 90 degrees left with a small non-square source.
		run_setting(100, 37, 37, 100, 16384, 0, 1, 80);
		// Oversized dimensions saturate; extreme trig values.
		run_setting(511, 300, 1023, 1023, -32768, 32767, $urandom_range(0, 1), 60);
		// Zero source height: nothing is inside.
		run_setting(0, 1, 0, 0, $urandom, $urandom, 0, 40);
		// One-pixel source and output.
		run_setting(1, 1, 1, 1, 0, 16384, 0, 40);
		// The unused register index is ignored by the unit.
		wait_until_drained();
		write_reg(REG_UNUSED, CDATA_W'($urandom));
		// Fully random registers.
		run_setting($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 1023),
			$urandom_range(0, 1023), $urandom, $urandom, $urandom_range(0, 1), 80);
		// 180 degrees left.
		run_setting(200, 256, 200, 256, 0, -16384, 1, 70);

		wait_until_drained();
		$display("Covered %0d store items and %0d fetch results, %0d of them inside the source,",
			stores_taken, fetches_checked, inside_hits);
		$display("across %0d register settings including saturated, empty and extreme ones.",
			settings_run);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* image_rotation_inverse_map_unit.f */
+incdir+sv
sv/irim_pkg.sv
sv/irim_cfg.sv
sv/irim_map.sv
sv/irim_mem.sv
sv/image_rotation_inverse_map_unit.sv
sim/image_rotation_inverse_map_unit_tb.sv
